@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
// Expects a clock i_clk and an active-low reset i_rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/spa_pkg.sv @@
// Types, constants and helpers for the sparse polynomial adder.
// No dependencies.
package spa_pkg;

    localparam int COEF_W        = 32;
    localparam int EXPON_W       = 16;
    localparam int MODE_W        = 2;
    localparam int MAX_TERMS_DEF = 32;

    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [EXPON_W-1:0]       expon;
    } t_term;

    typedef struct packed {
        logic signed [COEF_W-1:0] sum_coef;
        logic [EXPON_W-1:0]       sum_expon;
        logic                     last;
        logic                     empty_res;
        logic                     overflow;
    } t_res;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    function automatic logic signed [COEF_W-1:0] sat_add(
        input logic signed [COEF_W-1:0] a,
        input logic signed [COEF_W-1:0] b
    );
        logic signed [COEF_W:0] s;
        s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        if (s[COEF_W] != s[COEF_W-1]) begin
            sat_add = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
            sat_add = s[COEF_W-1:0];
        end
    endfunction

endpackage

@@ design/spa_if.sv @@
// Request and result channel interfaces for the sparse polynomial adder.
// Depends on spa_pkg.
interface spa_in_if
    import spa_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;

    modport source (output valid, output mode, output coef, output expon, input ready);
    modport sink   (input valid, input mode, input coef, input expon, output ready);
endinterface

interface spa_out_if
    import spa_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] sum_coef;
    logic [EXPON_W-1:0]       sum_expon;
    logic                     last;
    logic                     empty_res;
    logic                     overflow;

    modport source (output valid, output sum_coef, output sum_expon, output last,
                    output empty_res, output overflow, input ready);
    modport sink   (input valid, input sum_coef, input sum_expon, input last,
                    input empty_res, input overflow, output ready);
endinterface

@@ design/spa_term_mem.sv @@
// Term store: one write port, one read port with registered read data.
// Depends on spa_pkg.
module spa_term_mem
    import spa_pkg::*;
#(
    parameter int DEPTH = MAX_TERMS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_term            i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_term            o_rdata
);

    t_term mem [DEPTH];
    t_term r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sparse_polynomial_add_top.sv @@
// Sparse polynomial adder: two term stores loaded one term per cycle while idle, then merged.
// Load requests are taken back to back. Merge request: one step per cycle while the output
// is not stalled, no request taken meanwhile.
// Reset clears term counts, drop flag, merge control and output valid; stores are not cleared.
// Depends on spa_pkg, spa_if and spa_term_mem.
module sparse_polynomial_add_top
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spa_in_if.sink    i_req,
    spa_out_if.source o_res
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_TERMS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0] r_ptr_a, n_ptr_a, r_ptr_b, n_ptr_b;
    logic             r_dropped, n_dropped;
    logic             r_pend_valid, n_pend_valid;
    t_term            r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    logic  req_acc, can_push, a_live, b_live, merge_done;
    logic  we_a, we_b, nt_valid;
    t_term wr_term, rd_a, rd_b, nt;
    logic signed [COEF_W-1:0] s_coef;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign can_push    = !r_out_valid || o_res.ready;
    assign a_live      = r_ptr_a < r_cnt_a;
    assign b_live      = r_ptr_b < r_cnt_b;
    assign merge_done  = (r_state == ST_MERGE) && can_push && !a_live && !b_live;
    assign s_coef      = sat_add(rd_a.coef, rd_b.coef);
    assign wr_term     = '{coef: i_req.coef, expon: i_req.expon};

    spa_term_mem #(.DEPTH(MAX_TERMS), .IDX_W(IDX_W)) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (wr_term),
        .i_raddr (n_ptr_a[IDX_W-1:0]),
        .o_rdata (rd_a)
    );

    spa_term_mem #(.DEPTH(MAX_TERMS), .IDX_W(IDX_W)) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (wr_term),
        .i_raddr (n_ptr_b[IDX_W-1:0]),
        .o_rdata (rd_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc && i_req.mode == MODE_MERGE) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (merge_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_ptr_a      = r_ptr_a;
        n_ptr_b      = r_ptr_b;
        n_dropped    = r_dropped;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out        = r_out;
        we_a         = 1'b0;
        we_b         = 1'b0;
        nt_valid     = 1'b0;
        nt           = rd_a;
        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    case (i_req.mode)
                        MODE_FIRST: begin
                            if (r_cnt_a == FULL) begin
                                n_dropped = 1'b1;
                            end else begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + ONE;
                            end
                        end
                        MODE_SECOND: begin
                            if (r_cnt_b == FULL) begin
                                n_dropped = 1'b1;
                            end else begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + ONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE: begin
                if (can_push) begin
                    if (a_live && b_live) begin
                        if (rd_a.expon == rd_b.expon) begin
                            nt_valid = (s_coef != '0);
                            nt       = '{coef: s_coef, expon: rd_a.expon};
                            n_ptr_a  = r_ptr_a + ONE;
                            n_ptr_b  = r_ptr_b + ONE;
                        end else if (rd_a.expon < rd_b.expon) begin
                            nt_valid = 1'b1;
                            nt       = rd_b;
                            n_ptr_b  = r_ptr_b + ONE;
                        end else begin
                            nt_valid = 1'b1;
                            nt       = rd_a;
                            n_ptr_a  = r_ptr_a + ONE;
                        end
                    end else if (a_live) begin
                        nt_valid = 1'b1;
                        nt       = rd_a;
                        n_ptr_a  = r_ptr_a + ONE;
                    end else if (b_live) begin
                        nt_valid = 1'b1;
                        nt       = rd_b;
                        n_ptr_b  = r_ptr_b + ONE;
                    end else begin
                        n_out_valid = 1'b1;
                        if (r_pend_valid) begin
                            n_out = '{sum_coef: r_pend.coef, sum_expon: r_pend.expon,
                                      last: 1'b1, empty_res: 1'b0, overflow: r_dropped};
                        end else begin
                            n_out = '{sum_coef: '0, sum_expon: '0,
                                      last: 1'b1, empty_res: 1'b1, overflow: r_dropped};
                        end
                        n_pend_valid = 1'b0;
                        n_cnt_a      = '0;
                        n_cnt_b      = '0;
                        n_ptr_a      = '0;
                        n_ptr_b      = '0;
                        n_dropped    = 1'b0;
                    end
                    if (nt_valid) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out = '{sum_coef: r_pend.coef, sum_expon: r_pend.expon,
                                      last: 1'b0, empty_res: 1'b0, overflow: r_dropped};
                        end
                        n_pend       = nt;
                        n_pend_valid = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ptr_a      <= '0;
            r_ptr_b      <= '0;
            r_dropped    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_ptr_a      <= n_ptr_a;
            r_ptr_b      <= n_ptr_b;
            r_dropped    <= n_dropped;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.sum_coef  = r_out.sum_coef;
    assign o_res.sum_expon = r_out.sum_expon;
    assign o_res.last      = r_out.last;
    assign o_res.empty_res = r_out.empty_res;
    assign o_res.overflow  = r_out.overflow;

endmodule

@@ design/spa_checker.sv @@
// Port-level checks on the sparse polynomial adder, bound to the top level.
// Depends on spa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spa_checker
    import spa_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic [MODE_W-1:0]        i_in_mode,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [COEF_W-1:0] i_out_coef,
    input logic [EXPON_W-1:0]       i_out_expon,
    input logic                     i_out_last,
    input logic                     i_out_empty
);

    // stalled result holds
    `SPA_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_coef) && $stable(i_out_expon) && $stable(i_out_last))

    // an empty result is a lone zero item
    `SPA_ASSERT_IMP(a_empty_form, i_out_valid && i_out_empty, i_out_last && i_out_coef == '0 && i_out_expon == '0)

    // a merge request closes the input side
    `SPA_ASSERT_NXT(a_merge_busy, i_in_valid && i_in_ready && i_in_mode == MODE_MERGE, !i_in_ready)

    // a result that is not the last belongs to a running merge
    `SPA_ASSERT_IMP(a_mid_merge, i_out_valid && !i_out_last, !i_in_ready)

endmodule

bind sparse_polynomial_add_top spa_checker u_spa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_mode   (i_req.mode),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_coef  (o_res.sum_coef),
    .i_out_expon (o_res.sum_expon),
    .i_out_last  (o_res.last),
    .i_out_empty (o_res.empty_res)
);
